// File: hdl/lkw_pkg.sv
`default_nettype none

package lkw_pkg;

   localparam int unsigned LKW_QUEUE_DEPTH = 2;
   localparam int unsigned CSR_ADDR_WIDTH = 5;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [3:0] PROBE_LIMIT_RESET = 4'd3;
   localparam logic [7:0] STALL_LIMIT_RESET = 8'd15;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_FRAME = 2'd1,
      CMD_DISC  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      WHY_NONE       = 3'd0,
      WHY_INCOMPLETE = 3'd1,
      WHY_FOREIGN    = 3'd2,
      WHY_REJECTED   = 3'd3,
      WHY_STALLED    = 3'd4,
      WHY_TIMEOUT    = 3'd5,
      WHY_DISCONNECT = 3'd6
   } why_type;

   typedef enum logic [2:0] {
      REG_PROBE_CODE     = 3'd0,
      REG_ACK_CODE       = 3'd1,
      REG_PAYLOAD_CODE_A = 3'd2,
      REG_PAYLOAD_CODE_B = 3'd3,
      REG_PAYLOAD_CODE_C = 3'd4,
      REG_PAYLOAD_CODE_D = 3'd5,
      REG_PROBE_LIMIT    = 3'd6,
      REG_STALL_LIMIT    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [31:0] probe_code;
      logic [31:0] ack_code;
      logic [31:0] payload_code_a;
      logic [31:0] payload_code_b;
      logic [31:0] payload_code_c;
      logic [31:0] payload_code_d;
   } codes_type;

   typedef struct packed {
      logic [3:0] probe_limit;
      logic [7:0] stall_limit;
   } limits_type;

   typedef struct packed {
      cmd_type     cmd;
      logic        frame_ack;
      why_type     frame_why;
      logic        paused;
      logic [31:0] backlog;
      logic [63:0] written;
      logic [63:0] received;
   } item_type;

   typedef struct packed {
      logic    send_probe;
      logic    send_ack;
      logic    failed_now;
      why_type fail_reason;
      logic    link_active;
   } result_type;

endpackage

`default_nettype wire

// File: hdl/lkw_front.sv
`default_nettype none

module lkw_front (
   input  wire logic [1:0]        req_cmd,
   input  wire logic [31:0]       req_frame_code,
   input  wire logic              req_code_complete,
   input  wire logic              req_handler_accepted,
   input  wire logic              req_input_paused,
   input  wire logic [31:0]       req_buffered_output,
   input  wire logic [63:0]       req_bytes_written,
   input  wire logic [63:0]       req_bytes_received,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lkw_pkg::codes_type codes,
   input  wire logic              push_ready,
   output logic                   push,
   output lkw_pkg::item_type      push_item
);
   import lkw_pkg::*;

   logic is_payload;

   assign is_payload = (req_frame_code == codes.payload_code_a) ||
                       (req_frame_code == codes.payload_code_b) ||
                       (req_frame_code == codes.payload_code_c) ||
                       (req_frame_code == codes.payload_code_d);

   assign req_ready = push_ready;
   assign push      = req_valid && push_ready;

   always_comb begin
      push_item           = '0;
      push_item.cmd       = cmd_type'(req_cmd);
      push_item.paused    = req_input_paused;
      push_item.backlog   = req_buffered_output;
      push_item.written   = req_bytes_written;
      push_item.received  = req_bytes_received;
      push_item.frame_ack = 1'b0;
      push_item.frame_why = WHY_NONE;
      priority if (!req_code_complete) begin
         push_item.frame_why = WHY_INCOMPLETE;
      end else if (req_frame_code == codes.probe_code) begin
         push_item.frame_ack = 1'b1;
      end else if (req_frame_code == codes.ack_code) begin
         push_item.frame_why = WHY_NONE;
      end else if (!is_payload) begin
         push_item.frame_why = WHY_FOREIGN;
      end else if (!req_handler_accepted) begin
         push_item.frame_why = WHY_REJECTED;
      end else begin
         push_item.frame_why = WHY_NONE;
      end
   end

endmodule

`default_nettype wire

// File: hdl/lkw_queue.sv
`default_nettype none

module lkw_queue #(
   parameter int unsigned Depth = lkw_pkg::LKW_QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire lkw_pkg::item_type push_item,
   output logic                   push_ready,
   input  wire logic              pop,
   output lkw_pkg::item_type      pop_item,
   output logic                   pop_valid
);
   import lkw_pkg::*;

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

   item_type            entries_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: hdl/lkw_back.sv
`default_nettype none

module lkw_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lkw_pkg::limits_type limits,
   input  wire logic               pop_valid,
   input  wire lkw_pkg::item_type  pop_item,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output lkw_pkg::result_type     rsp_result
);
   import lkw_pkg::*;

   logic        active_ff, active_in;
   logic [3:0]  probes_ff, probes_in;
   logic [7:0]  stalled_ff, stalled_in;
   logic        frame_seen_ff, frame_seen_in;
   logic [31:0] last_backlog_ff, last_backlog_in;
   logic [63:0] last_written_ff, last_written_in;
   logic [63:0] last_received_ff, last_received_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_result_ff, rsp_result_in;

   why_type     why;
   logic        probe;
   logic        ack;
   logic        out_prog;
   logic        seen_backlog;
   logic        wr_prog;
   logic        in_prog;
   logic        started;
   logic        progress;
   logic [7:0]  stalled_inc;

   assign pop        = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   assign out_prog     = (last_backlog_ff != '0) && (pop_item.backlog < last_backlog_ff);
   assign seen_backlog = (last_backlog_ff != '0) || (pop_item.backlog != '0);
   assign wr_prog      = seen_backlog && (pop_item.written > last_written_ff);
   assign in_prog      = pop_item.received > last_received_ff;
   assign started      = (last_backlog_ff == '0) && (pop_item.backlog != '0);
   assign progress     = frame_seen_ff || in_prog || out_prog || wr_prog;
   assign stalled_inc  = stalled_ff + 8'd1;

   always_comb begin
      active_in        = active_ff;
      probes_in        = probes_ff;
      stalled_in       = stalled_ff;
      frame_seen_in    = frame_seen_ff;
      last_backlog_in  = last_backlog_ff;
      last_written_in  = last_written_ff;
      last_received_in = last_received_ff;
      why              = WHY_NONE;
      probe            = 1'b0;
      ack              = 1'b0;
      if (active_ff && pop_valid) begin
         unique case (pop_item.cmd)
            CMD_TICK: begin
               frame_seen_in    = 1'b0;
               last_backlog_in  = pop_item.backlog;
               last_written_in  = pop_item.written;
               last_received_in = pop_item.received;
               priority if (pop_item.paused) begin
                  probes_in  = '0;
                  stalled_in = '0;
                  probe      = 1'b1;
               end else if (progress) begin
                  probes_in  = '0;
                  stalled_in = '0;
               end else if (pop_item.backlog != '0) begin
                  probes_in = '0;
                  if (started) begin
                     stalled_in = '0;
                  end else begin
                     stalled_in = stalled_inc;
                     if (stalled_inc >= limits.stall_limit) begin
                        why = WHY_STALLED;
                     end
                  end
               end else begin
                  stalled_in = '0;
                  if (probes_ff >= limits.probe_limit) begin
                     why = WHY_TIMEOUT;
                  end else begin
                     probes_in = probes_ff + 4'd1;
                     probe     = 1'b1;
                  end
               end
            end
            CMD_FRAME: begin
               why = pop_item.frame_why;
               if (pop_item.frame_why == WHY_NONE) begin
                  probes_in     = '0;
                  stalled_in    = '0;
                  frame_seen_in = 1'b1;
                  ack           = pop_item.frame_ack;
               end
            end
            CMD_DISC: begin
               why = WHY_DISCONNECT;
            end
            CMD_NONE: begin
               why = WHY_NONE;
            end
         endcase
         if (why != WHY_NONE) begin
            active_in = 1'b0;
         end
      end
      rsp_result_in.send_probe  = probe;
      rsp_result_in.send_ack    = ack;
      rsp_result_in.failed_now  = (why != WHY_NONE);
      rsp_result_in.fail_reason = why;
      rsp_result_in.link_active = active_in;
      rsp_valid_in = pop ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff        <= 1'b1;
         probes_ff        <= '0;
         stalled_ff       <= '0;
         frame_seen_ff    <= 1'b0;
         last_backlog_ff  <= '0;
         last_written_ff  <= '0;
         last_received_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            active_ff        <= active_in;
            probes_ff        <= probes_in;
            stalled_ff       <= stalled_in;
            frame_seen_ff    <= frame_seen_in;
            last_backlog_ff  <= last_backlog_in;
            last_written_ff  <= last_written_in;
            last_received_ff <= last_received_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   a_closed_stays_closed: assert property (@(posedge clock) disable iff (reset)
      !active_ff |=> !active_ff)
      else $error("closed link reopened");

   a_fail_flag_matches_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_result_ff.failed_now == (rsp_result_ff.fail_reason != WHY_NONE)))
      else $error("failure flag disagrees with reason");

   a_fail_closes_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_result_ff.failed_now |-> !rsp_result_ff.link_active && !active_ff)
      else $error("failure left link open");

   a_probe_ack_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_result_ff.send_probe && rsp_result_ff.send_ack))
      else $error("probe and ack in one word");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: hdl/link_keepalive_watchdog.sv
`default_nettype none

// Keepalive watchdog for a bulk data link. Every input word (tick, received frame,
// disconnect or none) yields exactly one result word, at a sustained rate of one word per
// clock while rsp_ready stays high. An accepted word goes into the small queue between the
// classifier and the state unit and, once popped, into the result register at the rsp port;
// the queue depth (QueueDepth) sets how long the result side may stall before req_ready
// drops. Frame codes are compared against the programmed codes on entry, ticks are judged
// against the stored counters by the state unit (64-bit byte counts, 32-bit backlog).
// Program the registers over the csr port only while no word is in flight.

module link_keepalive_watchdog #(
   parameter int unsigned QueueDepth = lkw_pkg::LKW_QUEUE_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [1:0]                         req_cmd,
   input  wire logic [31:0]                        req_frame_code,
   input  wire logic                               req_code_complete,
   input  wire logic                               req_handler_accepted,
   input  wire logic                               req_input_paused,
   input  wire logic [31:0]                        req_buffered_output,
   input  wire logic [63:0]                        req_bytes_written,
   input  wire logic [63:0]                        req_bytes_received,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_send_probe,
   output logic                                    rsp_send_ack,
   output logic                                    rsp_failed_now,
   output logic [2:0]                              rsp_fail_reason,
   output logic                                    rsp_link_active,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [lkw_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [lkw_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [lkw_pkg::CSR_DATA_WIDTH-1:0]      csr_prdata,
   output logic                                    csr_pready
);
   import lkw_pkg::*;

   codes_type     codes_ff;
   limits_type    limits_ff;
   logic          csr_write;
   reg_index_type csr_index;

   logic          push;
   logic          push_ready;
   item_type      push_item;
   logic          pop;
   logic          pop_valid;
   item_type      pop_item;
   result_type    rsp_result;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff              <= '0;
         limits_ff.probe_limit <= PROBE_LIMIT_RESET;
         limits_ff.stall_limit <= STALL_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_PROBE_CODE:     codes_ff.probe_code     <= csr_pwdata;
            REG_ACK_CODE:       codes_ff.ack_code       <= csr_pwdata;
            REG_PAYLOAD_CODE_A: codes_ff.payload_code_a <= csr_pwdata;
            REG_PAYLOAD_CODE_B: codes_ff.payload_code_b <= csr_pwdata;
            REG_PAYLOAD_CODE_C: codes_ff.payload_code_c <= csr_pwdata;
            REG_PAYLOAD_CODE_D: codes_ff.payload_code_d <= csr_pwdata;
            REG_PROBE_LIMIT:    limits_ff.probe_limit   <= csr_pwdata[3:0];
            REG_STALL_LIMIT:    limits_ff.stall_limit   <= csr_pwdata[7:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_PROBE_CODE:     csr_prdata = codes_ff.probe_code;
         REG_ACK_CODE:       csr_prdata = codes_ff.ack_code;
         REG_PAYLOAD_CODE_A: csr_prdata = codes_ff.payload_code_a;
         REG_PAYLOAD_CODE_B: csr_prdata = codes_ff.payload_code_b;
         REG_PAYLOAD_CODE_C: csr_prdata = codes_ff.payload_code_c;
         REG_PAYLOAD_CODE_D: csr_prdata = codes_ff.payload_code_d;
         REG_PROBE_LIMIT:    csr_prdata = {28'd0, limits_ff.probe_limit};
         REG_STALL_LIMIT:    csr_prdata = {24'd0, limits_ff.stall_limit};
      endcase
   end

   lkw_front u_front (
      .req_cmd              (req_cmd),
      .req_frame_code       (req_frame_code),
      .req_code_complete    (req_code_complete),
      .req_handler_accepted (req_handler_accepted),
      .req_input_paused     (req_input_paused),
      .req_buffered_output  (req_buffered_output),
      .req_bytes_written    (req_bytes_written),
      .req_bytes_received   (req_bytes_received),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .codes                (codes_ff),
      .push_ready           (push_ready),
      .push                 (push),
      .push_item            (push_item)
   );

   lkw_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_item   (pop_item),
      .pop_valid  (pop_valid)
   );

   lkw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .limits     (limits_ff),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_send_probe  = rsp_result.send_probe;
   assign rsp_send_ack    = rsp_result.send_ack;
   assign rsp_failed_now  = rsp_result.failed_now;
   assign rsp_fail_reason = rsp_result.fail_reason;
   assign rsp_link_active = rsp_result.link_active;

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import lkw_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_PHASES = 6;
   localparam int WORDS_PER_PHASE = 215;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] code;
      logic        complete;
      logic        accepted;
      logic        paused;
      logic [31:0] backlog;
      logic [63:0] written;
      logic [63:0] received;
   } word_type;

   typedef struct packed {
      logic        active;
      logic [3:0]  probes;
      logic [7:0]  stalls;
      logic        frame_seen;
      logic [31:0] backlog;
      logic [63:0] written;
      logic [63:0] received;
   } link_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire logic   req_ready;
   logic [1:0]  req_cmd = CMD_NONE;
   logic [31:0] req_frame_code = '0;
   logic        req_code_complete = 1'b0;
   logic        req_handler_accepted = 1'b0;
   logic        req_input_paused = 1'b0;
   logic [31:0] req_buffered_output = '0;
   logic [63:0] req_bytes_written = '0;
   logic [63:0] req_bytes_received = '0;
   wire logic   rsp_valid;
   logic        rsp_ready = 1'b0;
   wire logic   rsp_send_probe;
   wire logic   rsp_send_ack;
   wire logic   rsp_failed_now;
   wire logic [2:0] rsp_fail_reason;
   wire logic   rsp_link_active;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   wire logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   wire logic   csr_pready;

   logic [31:0] code_probe = '0;
   logic [31:0] code_ack = '0;
   logic [31:0] code_payload [4] = '{default: '0};
   logic [3:0]  lim_probe = PROBE_LIMIT_RESET;
   logic [7:0]  lim_stall = STALL_LIMIT_RESET;
   link_state_type link = '{active: 1'b1, default: '0};

   result_type  due_verdicts [$];
   result_type  head_verdict;
   int          errors = 0;
   int          words_sent = 0;
   int          results_checked = 0;
   int          settings_used = 0;
   int          cycle_count = 0;
   int          stall_left = 0;
   logic        sender_pauses = 1'b1;
   logic        receiver_stalls = 1'b1;
   why_type     close_reason = WHY_NONE;

   link_keepalive_watchdog dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_frame_code(req_frame_code),
      .req_code_complete(req_code_complete),
      .req_handler_accepted(req_handler_accepted),
      .req_input_paused(req_input_paused),
      .req_buffered_output(req_buffered_output),
      .req_bytes_written(req_bytes_written),
      .req_bytes_received(req_bytes_received),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_send_probe(rsp_send_probe),
      .rsp_send_ack(rsp_send_ack),
      .rsp_failed_now(rsp_failed_now),
      .rsp_fail_reason(rsp_fail_reason),
      .rsp_link_active(rsp_link_active),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] pick_value32();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   function automatic logic [63:0] pick_value64();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic logic is_payload(logic [31:0] c);
      return c == code_payload[0] || c == code_payload[1] ||
             c == code_payload[2] || c == code_payload[3];
   endfunction

   task automatic judge_word(input word_type w, inout link_state_type s, output result_type r);
      why_type why;
      logic probe, ack, out_prog, seen_backlog, wr_prog, in_prog, started, progress;
      why = WHY_NONE;
      probe = 1'b0;
      ack = 1'b0;
      if (s.active) begin
         case (w.cmd)
            CMD_TICK: begin
               if (w.paused) begin
                  s.probes = '0;
                  s.stalls = '0;
                  s.frame_seen = 1'b0;
                  s.backlog = w.backlog;
                  s.written = w.written;
                  s.received = w.received;
                  probe = 1'b1;
               end else begin
                  out_prog = s.backlog != 0 && w.backlog < s.backlog;
                  seen_backlog = s.backlog != 0 || w.backlog != 0;
                  wr_prog = seen_backlog && w.written > s.written;
                  in_prog = w.received > s.received;
                  started = s.backlog == 0 && w.backlog != 0;
                  progress = s.frame_seen || in_prog || out_prog || wr_prog;
                  s.frame_seen = 1'b0;
                  s.backlog = w.backlog;
                  s.written = w.written;
                  s.received = w.received;
                  if (progress) begin
                     s.probes = '0;
                     s.stalls = '0;
                  end else if (w.backlog != 0) begin
                     s.probes = '0;
                     if (started) begin
                        s.stalls = '0;
                     end else begin
                        s.stalls = s.stalls + 8'd1;
                        if (s.stalls >= lim_stall) why = WHY_STALLED;
                     end
                  end else begin
                     s.stalls = '0;
                     if (s.probes >= lim_probe) begin
                        why = WHY_TIMEOUT;
                     end else begin
                        s.probes = s.probes + 4'd1;
                        probe = 1'b1;
                     end
                  end
               end
            end
            CMD_FRAME: begin
               if (!w.complete) begin
                  why = WHY_INCOMPLETE;
               end else if (w.code == code_probe) begin
                  ack = 1'b1;
               end else if (w.code != code_ack) begin
                  if (!is_payload(w.code)) why = WHY_FOREIGN;
                  else if (!w.accepted) why = WHY_REJECTED;
               end
               if (w.complete && why == WHY_NONE) begin
                  s.probes = '0;
                  s.stalls = '0;
                  s.frame_seen = 1'b1;
               end
            end
            CMD_DISC: why = WHY_DISCONNECT;
            default: ;
         endcase
         if (why != WHY_NONE) s.active = 1'b0;
      end
      r.send_probe = probe;
      r.send_ack = ack;
      r.failed_now = why != WHY_NONE;
      r.fail_reason = why;
      r.link_active = s.active;
   endtask

   function automatic word_type make_tick(logic paused, logic [31:0] backlog,
                                          logic [63:0] written, logic [63:0] received);
      word_type w;
      w.cmd = CMD_TICK;
      w.code = $urandom;
      w.complete = 1'($urandom_range(0, 1));
      w.accepted = 1'($urandom_range(0, 1));
      w.paused = paused;
      w.backlog = backlog;
      w.written = written;
      w.received = received;
      return w;
   endfunction

   function automatic word_type make_frame(logic [31:0] code, logic complete, logic accepted);
      word_type w;
      w = make_tick(1'($urandom_range(0, 1)), $urandom, {$urandom, $urandom},
                    {$urandom, $urandom});
      w.cmd = CMD_FRAME;
      w.code = code;
      w.complete = complete;
      w.accepted = accepted;
      return w;
   endfunction

   function automatic word_type draw_word();
      word_type w;
      int kind;
      w = make_frame($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      kind = $urandom_range(0, 99);
      if (kind < 18) begin
         w = make_tick(1'b0, '0, link.written, link.received);
      end else if (kind < 34) begin
         w = make_tick(1'b0, link.backlog != 0 ? link.backlog : 32'($urandom_range(1, 4096)),
                       link.written, link.received);
      end else if (kind < 50) begin
         w = make_tick(1'b0, link.backlog, link.written, link.received);
         case ($urandom_range(0, 2))
            0: w.received = link.received + $urandom_range(1, 9000);
            1: begin
               w.written = link.written + $urandom_range(1, 9000);
               if (w.backlog == 0) w.backlog = $urandom_range(1, 4096);
            end
            default: begin
               if (link.backlog != 0) w.backlog = link.backlog - $urandom_range(1, link.backlog);
            end
         endcase
      end else if (kind < 56) begin
         w = make_tick(1'b1, pick_value32(), pick_value64(), pick_value64());
      end else if (kind < 76) begin
         w.complete = 1'b1;
         w.accepted = $urandom_range(0, 7) != 0;
         case ($urandom_range(0, 5))
            0: w.code = code_probe;
            1: w.code = code_ack;
            default: w.code = code_payload[$urandom_range(0, 3)];
         endcase
      end else if (kind < 86) begin
         w.code = pick_value32();
      end else if (kind < 94) begin
         w = make_tick(1'b0, pick_value32(), pick_value64(), pick_value64());
      end else begin
         w.cmd = $urandom_range(0, 3) == 0 ? CMD_DISC : CMD_NONE;
      end
      return w;
   endfunction

   task automatic offer_word(input word_type w);
      int gap;
      result_type r;
      gap = sender_pauses ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_cmd <= w.cmd;
      req_frame_code <= w.code;
      req_code_complete <= w.complete;
      req_handler_accepted <= w.accepted;
      req_input_paused <= w.paused;
      req_buffered_output <= w.backlog;
      req_bytes_written <= w.written;
      req_bytes_received <= w.received;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      judge_word(w, link, r);
      due_verdicts.push_back(r);
      words_sent++;
   endtask

   // redraw anything that would close the link; a paused tick never does
   task automatic offer_live_word();
      word_type w;
      link_state_type trial;
      result_type r;
      int tries;
      for (tries = 0; tries < 16; tries++) begin
         w = draw_word();
         trial = link;
         judge_word(w, trial, r);
         if (trial.active) break;
      end
      if (!trial.active) begin
         w.cmd = CMD_TICK;
         w.paused = 1'b1;
      end
      offer_word(w);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (due_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_PROBE_CODE:     code_probe = value;
         REG_ACK_CODE:       code_ack = value;
         REG_PAYLOAD_CODE_A: code_payload[0] = value;
         REG_PAYLOAD_CODE_B: code_payload[1] = value;
         REG_PAYLOAD_CODE_C: code_payload[2] = value;
         REG_PAYLOAD_CODE_D: code_payload[3] = value;
         REG_PROBE_LIMIT:    lim_probe = value[3:0];
         REG_STALL_LIMIT:    lim_stall = value[7:0];
         default: ;
      endcase
   endtask

   task automatic program_link(input logic [31:0] probe, input logic [31:0] ack,
                               input logic [31:0] pa, input logic [31:0] pb,
                               input logic [31:0] pc, input logic [31:0] pd,
                               input logic [31:0] plim, input logic [31:0] slim);
      settle();
      write_reg(REG_PROBE_CODE, probe);
      write_reg(REG_ACK_CODE, ack);
      write_reg(REG_PAYLOAD_CODE_A, pa);
      write_reg(REG_PAYLOAD_CODE_B, pb);
      write_reg(REG_PAYLOAD_CODE_C, pc);
      write_reg(REG_PAYLOAD_CODE_D, pd);
      write_reg(REG_PROBE_LIMIT, plim);
      write_reg(REG_STALL_LIMIT, slim);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
         errors = errors + 1;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_verdicts.size() == 0) begin
            $display("%0t unexpected result word: expected none actual %0h", $time,
                     {rsp_send_probe, rsp_send_ack, rsp_failed_now, rsp_fail_reason,
                      rsp_link_active});
            errors = errors + 1;
         end else begin
            head_verdict = due_verdicts.pop_front();
            check_field("send_probe", 3'(head_verdict.send_probe), 3'(rsp_send_probe));
            check_field("send_ack", 3'(head_verdict.send_ack), 3'(rsp_send_ack));
            check_field("failed_now", 3'(head_verdict.failed_now), 3'(rsp_failed_now));
            check_field("fail_reason", head_verdict.fail_reason, rsp_fail_reason);
            check_field("link_active", 3'(head_verdict.link_active), 3'(rsp_link_active));
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
         stall_left <= pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   task automatic test_reset_defaults();
      offer_word('{cmd: CMD_NONE, default: '0});
      // all codes are zero after reset: a zero frame is a probe and gets an ack
      offer_word(make_frame('0, 1'b1, 1'b0));
      offer_word(make_tick(1'b0, '0, '0, '0));
      repeat (3) offer_word(make_tick(1'b0, '0, '0, '0));
      offer_word(make_tick(1'b1, '1, '1, '1));
      offer_word(make_tick(1'b0, '1, '1, '1));
      offer_word(make_tick(1'b0, '0, '0, '0));
   endtask

   task automatic test_frame_codes();
      // limit writes carry junk in the upper bits
      program_link(32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h8000_0000, 32'h5A5A_A5A5, 32'h0,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_word(make_frame(32'hFFFF_FFFF, 1'b1, 1'b0));
      offer_word(make_frame(32'h0, 1'b1, 1'b0));
      offer_word(make_frame(32'h0000_0001, 1'b1, 1'b1));
      offer_word(make_frame(32'h8000_0000, 1'b1, 1'b1));
      offer_word(make_frame(32'h5A5A_A5A5, 1'b1, 1'b1));
      offer_word(make_tick(1'b0, 32'd1, 64'd10, 64'd0));
      offer_word(make_tick(1'b0, 32'd1, 64'd10, 64'd0));
   endtask

   task automatic test_zero_limits();
      program_link(code_probe, code_ack, code_payload[0], code_payload[1], code_payload[2],
                   code_payload[3], 32'd0, 32'd0);
      offer_word(make_tick(1'b1, 32'd5, 64'd0, 64'd0));
      offer_word(make_tick(1'b0, 32'd4, 64'd0, 64'd0));
      offer_word(make_tick(1'b0, 32'd4, 64'd0, 64'd1));
      offer_word(make_frame(code_ack, 1'b1, 1'b0));
   endtask

   task automatic test_random_traffic();
      int phase;
      logic [31:0] c0, c1;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         c0 = $urandom;
         c1 = $urandom;
         case (phase)
            0: program_link(c0, c1, $urandom, $urandom, $urandom, $urandom, 32'd15, 32'd255);
            1: program_link(c0, c1, c0, c1, $urandom, $urandom, 32'd1, 32'd1);
            2: program_link(c0, c1, $urandom, $urandom, $urandom, $urandom, 32'd0, 32'd0);
            3: program_link('0, '1, '0, '1, 32'h0000_0001, 32'h8000_0000, 32'd15, 32'd255);
            default: program_link(c0, c1, $urandom, $urandom, $urandom, $urandom,
                                  ($urandom & 32'hFFFF_FFF0) | $urandom_range(1, 15),
                                  ($urandom & 32'hFFFF_FF00) | $urandom_range(1, 60));
         endcase
         sender_pauses = phase == 0 ? 1'b0 : phase == 1 ? 1'b1 : $urandom_range(0, 3) != 0;
         receiver_stalls = phase == 0 ? 1'b0 : phase == 1 ? 1'b1 : $urandom_range(0, 3) != 0;
         repeat (WORDS_PER_PHASE) offer_live_word();
      end
   endtask

   task automatic test_link_close();
      word_type w;
      why_type goal;
      int n;
      goal = why_type'($urandom_range(1, 6));
      program_link($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom_range(0, 15), $urandom_range(0, 40));
      sender_pauses = 1'b1;
      receiver_stalls = 1'b1;
      for (n = 0; n < 600 && link.active; n++) begin
         w = draw_word();
         case (goal)
            WHY_INCOMPLETE: w = make_frame($urandom, 1'b0, 1'($urandom_range(0, 1)));
            WHY_FOREIGN:    w = make_frame($urandom, 1'b1, 1'($urandom_range(0, 1)));
            WHY_REJECTED:   w = make_frame(code_payload[$urandom_range(0, 3)], 1'b1, 1'b0);
            WHY_STALLED: begin
               w = make_tick(1'b0, link.backlog != 0 ? link.backlog
                                                     : 32'($urandom_range(1, 65535)),
                             link.written, link.received);
            end
            WHY_TIMEOUT:    w = make_tick(1'b0, '0, link.written, link.received);
            default:        w.cmd = CMD_DISC;
         endcase
         offer_word(w);
      end
      if (link.active) begin
         w.cmd = CMD_DISC;
         goal = WHY_DISCONNECT;
         offer_word(w);
      end
      close_reason = goal;
      // the link stays closed: every further word is ignored
      repeat (24) offer_word(draw_word());
      settle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_frame_codes();
      test_zero_limits();
      test_random_traffic();
      test_link_close();
      $display("checked %0d result words for %0d words sent under %0d register settings",
               results_checked, words_sent, settings_used);
      $display("link closed at the end with reason %s", close_reason.name());
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
